// ===== hw/rtl/ssc_pkg.sv =====
// ============================================================================
// Sphere contact package
// Widths, constants and shared types of the sphere-sphere contact pipeline.
// ============================================================================
package ssc_pkg;

    localparam int COORD_W  = 32;
    localparam int RADIUS_W = 31;
    localparam int PEN_W    = 32;
    localparam int NORM_W   = 16;
    localparam int NORM_FB  = 14;
    localparam int THR_W    = 32;

    localparam int DIST2_W = 2 * COORD_W;
    localparam int SUM_W   = DIST2_W + 2;
    localparam int ROOT_W  = DIST2_W / 2;
    localparam int REM_W   = ROOT_W + 2;
    localparam int QUO_W   = NORM_FB + 1;
    localparam int NUM_W   = COORD_W + NORM_FB + 1;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(429497);
    localparam logic [QUO_W-1:0] NORM_ONE = {1'b1, {NORM_FB{1'b0}}};
    localparam logic signed [NORM_W-1:0] NORM_ONE_S = NORM_W'(NORM_ONE);

    typedef struct packed {
        logic signed [COORD_W-1:0] center_a_x;
        logic signed [COORD_W-1:0] center_a_y;
        logic signed [COORD_W-1:0] center_a_z;
        logic signed [COORD_W-1:0] center_b_x;
        logic signed [COORD_W-1:0] center_b_y;
        logic signed [COORD_W-1:0] center_b_z;
        logic [RADIUS_W-1:0]       radius_a;
        logic [RADIUS_W-1:0]       radius_b;
    } t_pair;

    typedef struct packed {
        logic                    hit;
        logic                    special;
        logic [PEN_W-1:0]        pen_fix;
        logic [PEN_W-1:0]        rsum;
        logic [2:0][COORD_W-1:0] mag;
        logic [2:0]              neg;
    } t_side;

endpackage

// ===== hw/rtl/ssc_if.sv =====
// ============================================================================
// Sphere contact channels
// Pair input channel, contact result channel and threshold write channel.
// ============================================================================
interface ssc_pair_if;
    import ssc_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] center_a_x;
    logic signed [COORD_W-1:0] center_a_y;
    logic signed [COORD_W-1:0] center_a_z;
    logic signed [COORD_W-1:0] center_b_x;
    logic signed [COORD_W-1:0] center_b_y;
    logic signed [COORD_W-1:0] center_b_z;
    logic [RADIUS_W-1:0]       radius_a;
    logic [RADIUS_W-1:0]       radius_b;
    modport source (output valid, center_a_x, center_a_y, center_a_z, center_b_x,
                    center_b_y, center_b_z, radius_a, radius_b, input ready);
    modport sink (input valid, center_a_x, center_a_y, center_a_z, center_b_x,
                  center_b_y, center_b_z, radius_a, radius_b, output ready);
endinterface

interface ssc_contact_if;
    import ssc_pkg::*;
    logic                     valid;
    logic                     ready;
    logic                     hit;
    logic [PEN_W-1:0]         penetration;
    logic signed [NORM_W-1:0] normal_x;
    logic signed [NORM_W-1:0] normal_y;
    logic signed [NORM_W-1:0] normal_z;
    modport source (output valid, hit, penetration, normal_x, normal_y, normal_z,
                    input ready);
    modport sink (input valid, hit, penetration, normal_x, normal_y, normal_z,
                  output ready);
endinterface

interface ssc_cfg_if;
    import ssc_pkg::*;
    logic             valid;
    logic             ready;
    logic [THR_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ===== hw/rtl/sphere_sphere_contact.sv =====
// ============================================================================
// Sphere-sphere contact
// Overlap test, penetration depth and contact normal for one sphere pair.
// ============================================================================
//  Channel    Dir  Beat
//  i_pair     in   two centres (Q15.16) and two radii (Q15.16)
//  o_contact  out  hit, penetration (Q16.16), normal (Q1.14)
//  i_cfg      in   coincidence threshold (Q0.32)
//
// One beat is accepted per cycle while the output is not stalled; a result
// passes the five front stages, the 32-stage square root, the 16-stage divider
// and the output register. Reset empties the pipeline and reloads the
// threshold. A stalled output freezes every stage, and i_pair.ready follows it.
module sphere_sphere_contact (
    input logic           i_clk,
    input logic           i_rst_n,
    ssc_pair_if.sink      i_pair,
    ssc_contact_if.source o_contact,
    ssc_cfg_if.sink       i_cfg
);
    import ssc_pkg::*;

    typedef struct packed {
        logic                     hit;
        logic [PEN_W-1:0]         penetration;
        logic signed [NORM_W-1:0] normal_x;
        logic signed [NORM_W-1:0] normal_y;
        logic signed [NORM_W-1:0] normal_z;
    } t_res;

    logic                  w_en;
    t_pair                 w_pair;
    logic [THR_W-1:0]      r_thr;
    logic                  w_f_vld, w_s_vld, w_d_vld;
    t_side                 w_f_side, w_s_side, w_d_side;
    logic [DIST2_W-1:0]    w_dist2;
    logic [ROOT_W-1:0]     w_dist, w_d_dist;
    logic [2:0][QUO_W-1:0] w_quo;
    logic [NORM_W-1:0]     w_n [3];
    t_res                  n_out, r_out;
    logic                  r_out_vld;

    assign w_en = !r_out_vld || o_contact.ready;
    assign i_pair.ready = w_en;
    assign i_cfg.ready  = 1'b1;

    assign w_pair.center_a_x = i_pair.center_a_x;
    assign w_pair.center_a_y = i_pair.center_a_y;
    assign w_pair.center_a_z = i_pair.center_a_z;
    assign w_pair.center_b_x = i_pair.center_b_x;
    assign w_pair.center_b_y = i_pair.center_b_y;
    assign w_pair.center_b_z = i_pair.center_b_z;
    assign w_pair.radius_a   = i_pair.radius_a;
    assign w_pair.radius_b   = i_pair.radius_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg.valid) begin
            r_thr <= i_cfg.data;
        end
    end

    ssc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_pair.valid),
        .i_pair  (w_pair),
        .i_thr   (r_thr),
        .o_vld   (w_f_vld),
        .o_side  (w_f_side),
        .o_dist2 (w_dist2)
    );

    ssc_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_f_vld),
        .i_side  (w_f_side),
        .i_dist2 (w_dist2),
        .o_vld   (w_s_vld),
        .o_side  (w_s_side),
        .o_dist  (w_dist)
    );

    ssc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_s_vld),
        .i_side  (w_s_side),
        .i_dist  (w_dist),
        .o_vld   (w_d_vld),
        .o_side  (w_d_side),
        .o_dist  (w_d_dist),
        .o_quo   (w_quo)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic [QUO_W-1:0] q;
            q = (w_quo[i] > NORM_ONE) ? NORM_ONE : w_quo[i];
            w_n[i] = w_d_side.neg[i] ? NORM_W'(-NORM_W'(q)) : NORM_W'(q);
        end
        n_out = '0;
        if (w_d_side.hit) begin
            n_out.hit = 1'b1;
            if (w_d_side.special) begin
                n_out.penetration = w_d_side.pen_fix;
                n_out.normal_y    = NORM_ONE_S;
            end else begin
                n_out.penetration = w_d_side.rsum - PEN_W'(w_d_dist);
                n_out.normal_x    = w_n[0];
                n_out.normal_y    = w_n[1];
                n_out.normal_z    = w_n[2];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_contact.valid       = r_out_vld;
    assign o_contact.hit         = r_out.hit;
    assign o_contact.penetration = r_out.penetration;
    assign o_contact.normal_x    = r_out.normal_x;
    assign o_contact.normal_y    = r_out.normal_y;
    assign o_contact.normal_z    = r_out.normal_z;

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !r_out.hit |-> r_out.penetration == '0 && r_out.normal_x == '0
            && r_out.normal_y == '0 && r_out.normal_z == '0)
        else $error("Missed pair carries a non-zero contact.");

    a_normal_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out.hit |-> r_out.normal_x <= NORM_ONE_S
            && r_out.normal_x >= -NORM_ONE_S && r_out.normal_z <= NORM_ONE_S
            && r_out.normal_z >= -NORM_ONE_S)
        else $error("Normal component outside the unit range.");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !r_out_vld)
        else $error("Result shown straight after reset.");

    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_out_vld) && $stable(w_d_vld))
        else $error("Pipeline moved during a stall.");

endmodule

// ===== hw/rtl/ssc_front.sv =====
// ============================================================================
// Sphere contact front end
// Offsets, squares, squared distance and the hit and coincidence tests.
// ============================================================================
module ssc_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_vld,
    input  ssc_pkg::t_pair                i_pair,
    input  logic [ssc_pkg::THR_W-1:0]     i_thr,
    output logic                          o_vld,
    output ssc_pkg::t_side                o_side,
    output logic [ssc_pkg::DIST2_W-1:0]   o_dist2
);
    import ssc_pkg::*;

    typedef struct packed {
        logic [2:0][COORD_W-1:0] mag;
        logic [2:0]              neg;
        logic [PEN_W-1:0]        rsum;
        logic [RADIUS_W-1:0]     ra;
    } t_carry;

    logic signed [COORD_W:0] w_d [3];
    logic [4:0]              r_vld;
    t_carry                  n_c1;
    t_carry                  r_c1, r_c2, r_c3, r_c4;
    logic [DIST2_W-1:0]      r2_sq [3];
    logic [DIST2_W-1:0]      r2_rsum2, r3_rsum2, r4_rsum2;
    logic [DIST2_W:0]        r3_s01;
    logic [DIST2_W-1:0]      r3_sq2;
    logic [SUM_W-1:0]        r4_sum;
    logic [DIST2_W-1:0]      w_d2;
    logic                    w_over, w_coin;
    t_side                   r_side;
    logic [DIST2_W-1:0]      r_dist2;

    assign w_d[0] = (COORD_W+1)'(i_pair.center_b_x) - (COORD_W+1)'(i_pair.center_a_x);
    assign w_d[1] = (COORD_W+1)'(i_pair.center_b_y) - (COORD_W+1)'(i_pair.center_a_y);
    assign w_d[2] = (COORD_W+1)'(i_pair.center_b_z) - (COORD_W+1)'(i_pair.center_a_z);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_c1.neg[i] = w_d[i][COORD_W];
            n_c1.mag[i] = w_d[i][COORD_W] ? COORD_W'(-w_d[i]) : COORD_W'(w_d[i]);
        end
        n_c1.rsum = PEN_W'(i_pair.radius_a) + PEN_W'(i_pair.radius_b);
        n_c1.ra   = i_pair.radius_a;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c1 <= n_c1;
            r_c2 <= r_c1;
            r_c3 <= r_c2;
            r_c4 <= r_c3;
            for (int i = 0; i < 3; i++) begin
                r2_sq[i] <= DIST2_W'(r_c1.mag[i]) * DIST2_W'(r_c1.mag[i]);
            end
            r2_rsum2 <= DIST2_W'(r_c1.rsum) * DIST2_W'(r_c1.rsum);
            r3_s01   <= (DIST2_W+1)'(r2_sq[0]) + (DIST2_W+1)'(r2_sq[1]);
            r3_sq2   <= r2_sq[2];
            r3_rsum2 <= r2_rsum2;
            r4_sum   <= SUM_W'(r3_s01) + SUM_W'(r3_sq2);
            r4_rsum2 <= r3_rsum2;
        end
    end

    assign w_over = |r4_sum[SUM_W-1:DIST2_W];
    assign w_d2   = r4_sum[DIST2_W-1:0];
    assign w_coin = w_d2 < DIST2_W'(i_thr);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side.hit     <= !w_over && (w_d2 <= r4_rsum2);
            r_side.special <= w_coin || (w_d2 == '0);
            r_side.pen_fix <= w_coin ? PEN_W'(r_c4.ra) : r_c4.rsum;
            r_side.rsum    <= r_c4.rsum;
            r_side.mag     <= r_c4.mag;
            r_side.neg     <= r_c4.neg;
            r_dist2        <= w_d2;
        end
    end

    assign o_vld   = r_vld[4];
    assign o_side  = r_side;
    assign o_dist2 = r_dist2;

endmodule

// ===== hw/rtl/ssc_sqrt.sv =====
// ============================================================================
// Sphere contact square root
// Pipelined integer square root, one result bit per stage.
// ============================================================================
module ssc_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_vld,
    input  ssc_pkg::t_side                i_side,
    input  logic [ssc_pkg::DIST2_W-1:0]   i_dist2,
    output logic                          o_vld,
    output ssc_pkg::t_side                o_side,
    output logic [ssc_pkg::ROOT_W-1:0]    o_dist
);
    import ssc_pkg::*;

    logic [ROOT_W-1:0]  r_vld;
    logic [REM_W-1:0]   r_rem  [ROOT_W];
    logic [ROOT_W-1:0]  r_root [ROOT_W];
    logic [DIST2_W-1:0] r_val  [ROOT_W];
    t_side              r_side [ROOT_W];
    logic [REM_W-1:0]   w_rem  [ROOT_W+1];
    logic [ROOT_W-1:0]  w_root [ROOT_W+1];
    logic [DIST2_W-1:0] w_val  [ROOT_W+1];
    t_side              w_side [ROOT_W+1];

    assign w_rem[0]  = '0;
    assign w_root[0] = '0;
    assign w_val[0]  = i_dist2;
    assign w_side[0] = i_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[ROOT_W-2:0], i_vld};
        end
    end

    for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
        logic [REM_W+1:0] w_cur;
        logic [REM_W+1:0] w_trial;
        logic             w_take;

        assign w_cur   = {w_rem[g], w_val[g][DIST2_W-1 -: 2]};
        assign w_trial = (REM_W+2)'({w_root[g], 2'b01});
        assign w_take  = w_cur >= w_trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= w_take ? REM_W'(w_cur - w_trial) : REM_W'(w_cur);
                r_root[g] <= {w_root[g][ROOT_W-2:0], w_take};
                r_val[g]  <= w_val[g] << 2;
                r_side[g] <= w_side[g];
            end
        end

        assign w_rem[g+1]  = r_rem[g];
        assign w_root[g+1] = r_root[g];
        assign w_val[g+1]  = r_val[g];
        assign w_side[g+1] = r_side[g];
    end

    assign o_vld  = r_vld[ROOT_W-1];
    assign o_side = w_side[ROOT_W];
    assign o_dist = w_root[ROOT_W];

endmodule

// ===== hw/rtl/ssc_div.sv =====
// ============================================================================
// Sphere contact normal divider
// Three lanes of pipelined restoring division, one quotient bit per stage.
// ============================================================================
module ssc_div (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_vld,
    input  ssc_pkg::t_side                        i_side,
    input  logic [ssc_pkg::ROOT_W-1:0]            i_dist,
    output logic                                  o_vld,
    output ssc_pkg::t_side                        o_side,
    output logic [ssc_pkg::ROOT_W-1:0]            o_dist,
    output logic [2:0][ssc_pkg::QUO_W-1:0]        o_quo
);
    import ssc_pkg::*;

    logic [QUO_W:0]            r_vld;
    logic [2:0][NUM_W-1:0]     r_num;
    logic [ROOT_W-1:0]         r_pdist;
    t_side                     r_pside;
    logic [2:0][NUM_W-1:0]     r_rem  [QUO_W];
    logic [2:0][QUO_W-1:0]     r_quo  [QUO_W];
    logic [ROOT_W-1:0]         r_dist [QUO_W];
    t_side                     r_side [QUO_W];
    logic [2:0][NUM_W-1:0]     w_rem  [QUO_W+1];
    logic [2:0][QUO_W-1:0]     w_quo  [QUO_W+1];
    logic [ROOT_W-1:0]         w_dist [QUO_W+1];
    t_side                     w_side [QUO_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[QUO_W-1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_num[i] <= (NUM_W'(i_side.mag[i]) << NORM_FB) + NUM_W'(i_dist >> 1);
            end
            r_pdist <= i_dist;
            r_pside <= i_side;
        end
    end

    assign w_rem[0]  = r_num;
    assign w_quo[0]  = '0;
    assign w_dist[0] = r_pdist;
    assign w_side[0] = r_pside;

    for (genvar g = 0; g < QUO_W; g++) begin : g_stage
        logic [NUM_W-1:0] w_sub;
        logic [2:0]       w_take;

        assign w_sub = NUM_W'(w_dist[g]) << (NORM_FB - g);

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                w_take[i] = w_rem[g][i] >= w_sub;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int i = 0; i < 3; i++) begin
                    r_rem[g][i] <= w_take[i] ? w_rem[g][i] - w_sub : w_rem[g][i];
                    r_quo[g][i] <= {w_quo[g][i][QUO_W-2:0], w_take[i]};
                end
                r_dist[g] <= w_dist[g];
                r_side[g] <= w_side[g];
            end
        end

        assign w_rem[g+1]  = r_rem[g];
        assign w_quo[g+1]  = r_quo[g];
        assign w_dist[g+1] = r_dist[g];
        assign w_side[g+1] = r_side[g];
    end

    assign o_vld  = r_vld[QUO_W];
    assign o_side = w_side[QUO_W];
    assign o_dist = w_dist[QUO_W];
    assign o_quo  = w_quo[QUO_W];

endmodule

// ===== verif/sphere_sphere_contact_test.sv =====
// ============================================================================
// Sphere-sphere contact testbench
// Drives sphere pairs and threshold writes into the contact block, predicts
// every contact result in fixed point and checks the results in order, with
// random stalls on both channels.
// ============================================================================
`timescale 1ns / 1ps

module sphere_sphere_contact_test;
    import ssc_pkg::*;

    typedef struct {
        bit                     hit;
        bit [PEN_W-1:0]         penetration;
        bit signed [NORM_W-1:0] normal_x;
        bit signed [NORM_W-1:0] normal_y;
        bit signed [NORM_W-1:0] normal_z;
    } t_contact;

    class contact_scoreboard;
        t_contact        pending[$];
        bit [THR_W-1:0]  threshold;
        int              errors;

        function new();
            threshold = THR_RESET;
            errors = 0;
        endfunction

        function bit [63:0] floor_root(bit [63:0] v);
            bit [63:0] res;
            bit [63:0] one_bit;
            res = 0;
            one_bit = 64'd1 << 62;
            while (one_bit > v) one_bit = one_bit >> 2;
            while (one_bit != 0) begin
                if (v >= res + one_bit) begin
                    v = v - (res + one_bit);
                    res = (res >> 1) + one_bit;
                end else begin
                    res = res >> 1;
                end
                one_bit = one_bit >> 2;
            end
            return res;
        endfunction

        function t_contact predict_contact(t_pair p);
            bit signed [63:0] ca[3];
            bit signed [63:0] cb[3];
            bit [63:0]        d;
            bit [63:0]        mag[3];
            bit               neg[3];
            bit [64:0]        dist2;
            bit               over;
            bit [63:0]        rsum;
            bit [63:0]        rsum2;
            bit [63:0]        root;
            bit [63:0]        q;
            bit [63:0]        sq;
            bit [NORM_W-1:0]  comp[3];
            t_contact         r;
            ca[0] = $signed(p.center_a_x);
            ca[1] = $signed(p.center_a_y);
            ca[2] = $signed(p.center_a_z);
            cb[0] = $signed(p.center_b_x);
            cb[1] = $signed(p.center_b_y);
            cb[2] = $signed(p.center_b_z);
            dist2 = 0;
            over = 0;
            for (int i = 0; i < 3; i++) begin
                d = cb[i] - ca[i];
                neg[i] = d[63];
                mag[i] = neg[i] ? -d : d;
                if (mag[i][63:32] != 0) begin
                    over = 1;
                end else begin
                    sq = mag[i] * mag[i];
                    dist2 = dist2 + {1'b0, sq};
                    if (dist2[64]) over = 1;
                    dist2[64] = 0;
                end
            end
            rsum = 64'(p.radius_a) + 64'(p.radius_b);
            rsum2 = rsum * rsum;
            r = '{default: 0};
            if (over || dist2[63:0] > rsum2) return r;
            r.hit = 1;
            if (dist2[63:0] < 64'(threshold)) begin
                r.penetration = PEN_W'(p.radius_a);
                r.normal_y = NORM_ONE_S;
            end else if (dist2 == 0) begin
                r.penetration = rsum[PEN_W-1:0];
                r.normal_y = NORM_ONE_S;
            end else begin
                root = floor_root(dist2[63:0]);
                r.penetration = PEN_W'(rsum - root);
                for (int i = 0; i < 3; i++) begin
                    q = ((mag[i] << NORM_FB) + (root >> 1)) / root;
                    if (q > 64'(NORM_ONE)) q = 64'(NORM_ONE);
                    if (neg[i]) q = -q;
                    comp[i] = q[NORM_W-1:0];
                end
                r.normal_x = comp[0];
                r.normal_y = comp[1];
                r.normal_z = comp[2];
            end
            return r;
        endfunction

        function void note_pair(t_pair p);
            pending.insert(pending.size(), predict_contact(p));
        endfunction

        function void check_contact(t_contact got);
            t_contact want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected contact beat hit=%0d pen=%h", $time, got.hit,
                         got.penetration);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.hit != want.hit) begin
                $display("%0t: hit expected %0d actual %0d", $time, want.hit, got.hit);
                errors++;
            end
            if (got.penetration != want.penetration) begin
                $display("%0t: penetration expected %h actual %h", $time,
                         want.penetration, got.penetration);
                errors++;
            end
            if (got.normal_x != want.normal_x) begin
                $display("%0t: normal_x expected %0d actual %0d", $time, want.normal_x,
                         got.normal_x);
                errors++;
            end
            if (got.normal_y != want.normal_y) begin
                $display("%0t: normal_y expected %0d actual %0d", $time, want.normal_y,
                         got.normal_y);
                errors++;
            end
            if (got.normal_z != want.normal_z) begin
                $display("%0t: normal_z expected %0d actual %0d", $time, want.normal_z,
                         got.normal_z);
                errors++;
            end
        endfunction
    endclass

    localparam int CYCLE_LIMIT = 400000;

    logic i_clk;
    logic i_rst_n;

    ssc_pair_if    pair_ch();
    ssc_contact_if contact_ch();
    ssc_cfg_if     cfg_ch();

    sphere_sphere_contact i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_pair   (pair_ch.sink),
        .o_contact(contact_ch.source),
        .i_cfg    (cfg_ch.sink)
    );

    contact_scoreboard board;
    int                send_idle_pct;
    int                recv_idle_pct;
    int                cycles = 0;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_contact got;
        if (i_rst_n && contact_ch.valid && contact_ch.ready) begin
            got.hit = contact_ch.hit;
            got.penetration = contact_ch.penetration;
            got.normal_x = contact_ch.normal_x;
            got.normal_y = contact_ch.normal_y;
            got.normal_z = contact_ch.normal_z;
            board.check_contact(got);
        end
        contact_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_pair(t_pair item);
        while ($urandom_range(99) < send_idle_pct) begin
            pair_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        pair_ch.valid <= 1'b1;
        pair_ch.center_a_x <= item.center_a_x;
        pair_ch.center_a_y <= item.center_a_y;
        pair_ch.center_a_z <= item.center_a_z;
        pair_ch.center_b_x <= item.center_b_x;
        pair_ch.center_b_y <= item.center_b_y;
        pair_ch.center_b_z <= item.center_b_z;
        pair_ch.radius_a <= item.radius_a;
        pair_ch.radius_b <= item.radius_b;
        do @(posedge i_clk); while (!pair_ch.ready);
        board.note_pair(item);
    endtask

    task automatic drain();
        pair_ch.valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_threshold(bit [THR_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        board.threshold = value;
    endtask

    function automatic t_pair make_pair(int ax, int ay, int az, int bx, int by, int bz,
                                        int ra, int rb);
        t_pair r;
        r.center_a_x = ax;
        r.center_a_y = ay;
        r.center_a_z = az;
        r.center_b_x = bx;
        r.center_b_y = by;
        r.center_b_z = bz;
        r.radius_a = RADIUS_W'(ra);
        r.radius_b = RADIUS_W'(rb);
        return r;
    endfunction

    function automatic t_pair random_pair();
        t_pair r;
        int    kind;
        int    span;
        kind = $urandom_range(99);
        r.center_a_x = $urandom;
        r.center_a_y = $urandom;
        r.center_a_z = $urandom;
        r.radius_a = RADIUS_W'($urandom);
        r.radius_b = RADIUS_W'($urandom);
        if (kind < 60) begin
            span = 1 << $urandom_range(24, 4);
            r.center_b_x = r.center_a_x + $signed($urandom_range(2 * span)) - span;
            r.center_b_y = r.center_a_y + $signed($urandom_range(2 * span)) - span;
            r.center_b_z = r.center_a_z + $signed($urandom_range(2 * span)) - span;
            r.radius_a = RADIUS_W'($urandom_range(2 * span));
            r.radius_b = RADIUS_W'($urandom_range(2 * span));
        end else if (kind < 80) begin
            r.center_b_x = r.center_a_x + $signed($urandom_range(16)) - 8;
            r.center_b_y = r.center_a_y + $signed($urandom_range(16)) - 8;
            r.center_b_z = r.center_a_z + $signed($urandom_range(16)) - 8;
            r.radius_a = RADIUS_W'($urandom_range(1 << 20));
        end else begin
            r.center_b_x = $urandom;
            r.center_b_y = $urandom;
            r.center_b_z = $urandom;
        end
        return r;
    endfunction

    task automatic run_random(int count);
        repeat (count) send_pair(random_pair());
    endtask

    initial begin
        board = new();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        i_rst_n = 1'b0;
        pair_ch.valid = 1'b0;
        pair_ch.center_a_x = 0;
        pair_ch.center_a_y = 0;
        pair_ch.center_a_z = 0;
        pair_ch.center_b_x = 0;
        pair_ch.center_b_y = 0;
        pair_ch.center_b_z = 0;
        pair_ch.radius_a = 0;
        pair_ch.radius_b = 0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed pairs at the reset threshold.
        send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
        send_pair(make_pair(0, 0, 0, 65536, 0, 0, 32768, 32768));
        send_pair(make_pair(0, 0, 0, 65537, 0, 0, 32768, 32768));
        send_pair(make_pair(100, -5, 7, 100, -5, 7, 65536, 131072));
        send_pair(make_pair(0, 0, 0, 3, 4, 0, 1000, 0));
        send_pair(make_pair(-2147483648, -2147483648, -2147483648,
                            2147483647, 2147483647, 2147483647,
                            31'h7fffffff, 31'h7fffffff));
        send_pair(make_pair(2147483647, 0, 0, -2147483648, 0, 0,
                            31'h7fffffff, 31'h7fffffff));
        send_pair(make_pair(0, 0, 0, 0, -2147483648, 0, 31'h7fffffff, 31'h7fffffff));
        send_pair(make_pair(0, 0, 0, -65536, -65536, -65536, 200000, 0));
        send_pair(make_pair(0, 0, 0, 65536, -65536, 65536, 0, 31'h7fffffff));
        send_pair(make_pair(5, 5, 5, 6, 5, 5, 0, 1));
        send_pair(make_pair(0, 0, 0, 1000, 2000, -3000, 1, 0));
        drain();

        write_threshold('0);
        send_pair(make_pair(7, 7, 7, 7, 7, 7, 65536, 65536));
        send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
        send_pair(make_pair(0, 0, 0, 1, 0, 0, 1, 0));
        send_idle_pct = 11;
        recv_idle_pct = 51;
        run_random(230);
        drain();

        write_threshold('1);
        send_idle_pct = 51;
        recv_idle_pct = 11;
        run_random(230);
        drain();

        write_threshold($urandom_range(1 << 24));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(240);
        drain();

        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
